// ----- hw/rtl/tspr_pkg.sv -----
// ----------------------------------------------------------------------------
// tspr_pkg
// Shared types, codes and helpers of the timed sample playback ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tspr_pkg;

   // ring geometry and release limit
   localparam int RING_DEPTH  = 16;
   localparam int JOINT_COUNT = 4;
   localparam int MAX_RESULTS = 16;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int OCC_W = $clog2(RING_DEPTH + 1);
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   // command codes
   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_STORE   = 3'd0;
   localparam cmd_type CMD_START   = 3'd1;
   localparam cmd_type CMD_TICK    = 3'd2;
   localparam cmd_type CMD_STOP    = 3'd3;
   localparam cmd_type CMD_DISCARD = 3'd4;

   // status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   // input item
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] now_us;
      logic [63:0] joint_set;
      logic [31:0] interval_us;
   } req_type;

   // result item
   typedef struct packed {
      status_type  status;
      logic        applied;
      logic [63:0] drive_set;
      logic [4:0]  vacancy;
      logic        finished;
      logic        last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // latch the accepted item
      logic exec;       // run a single-result command
      logic pop;        // release the head set into the pending slot
      logic emit_prev;  // send the pending result along with a pop
      logic flush;      // send the pending result as the final one
      logic idle_ack;   // tick that released nothing
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic due_ok;     // playing, ring not empty and head set is due
   } sts_type;

   // mask of the joints that are kept
   function automatic logic [63:0] joint_mask_f();
      logic [63:0] m;
      m = '0;
      for (int j = 0; j < 4; j++) begin
         if (j < JOINT_COUNT) begin
            m[16*j +: 16] = 16'hFFFF;
         end
      end
      return m;
   endfunction

   localparam logic [63:0] JOINT_MASK = joint_mask_f();

   // ring pointer advance with wrap
   function automatic logic [PTR_W-1:0] ptr_next_f(logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // empty entries, reported in five bits
   function automatic logic [4:0] vacancy_f(logic [OCC_W-1:0] occ);
      return 5'(RING_DEPTH) - 5'(occ);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/timed_sample_playback_ring_unit.sv -----
// ----------------------------------------------------------------------------
// timed_sample_playback_ring_unit
// Paced playback ring of joint-position sets with store, start, tick, stop
// and discard commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every result appears
// for one cycle with rsp_valid and must be taken then, since the receiver
// cannot stall the block. Store, start, stop, discard and unused commands give
// one result: the item is latched, the exec state runs the command and its
// result is registered, then the block is free again. A tick passes through
// the eval and wait states per released set (at most 16), because the ring
// memory read of the next head set is registered and each release waits for
// it; results of a tick come one behind the release that caused them, the last marked by last.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_sample_playback_ring_unit
   import tspr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   ctl_type ctl;
   sts_type sts;

   // sequencer
   tspr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .sts     (sts),
      .busy    (busy),
      .ctl     (ctl)
   );

   // ring and timeline
   tspr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/tspr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tspr_ctrl
// Sequencer: accepts items, runs single commands and steps the tick release
// loop one ring entry at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tspr_ctrl
   import tspr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire cmd_type req_cmd,
   input  wire sts_type sts,
   output logic         busy,
   output ctl_type      ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EVAL,
      ST_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               cnt_in   = '0;
               state_in = (req_cmd == CMD_TICK) ? ST_EVAL : ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EVAL: begin
            if (sts.due_ok && (cnt_ff < CNT_W'(MAX_RESULTS))) begin
               ctl.pop       = 1'b1;
               ctl.emit_prev = (cnt_ff != '0);
               cnt_in        = cnt_ff + 1'b1;
               state_in      = ST_WAIT;
            end else if (cnt_ff != '0) begin
               ctl.flush = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               ctl.idle_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_WAIT: begin
            // ring read data catches up with the new head
            state_in = ST_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tspr_datapath.sv -----
// ----------------------------------------------------------------------------
// tspr_datapath
// Ring storage, pointers, playback timeline and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tspr_datapath
   import tspr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire ctl_type     ctl,
   output sts_type          sts,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   // ring memories
   logic [63:0] set_mem  [RING_DEPTH];
   logic [31:0] ival_mem [RING_DEPTH];
   logic        mem_we;

   req_type          item_ff, item_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [31:0]      consumed_ff, consumed_in;
   logic             playing_ff, playing_in;
   logic [31:0]      start_time_ff, start_time_in;
   logic [31:0]      due_ff, due_in;
   logic [31:0]      total_ff;
   logic [63:0]      set_rd_ff;
   logic [31:0]      ival_rd_ff;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   status_type       status;
   logic [31:0]      elapsed;
   logic             fin_now;
   logic             fin_next;

   assign elapsed   = item_ff.now_us - start_time_ff;
   assign sts.due_ok = playing_ff && (occ_ff != '0) && (elapsed >= due_ff);
   assign csr_ready = 1'b1;

   // next ring and timeline state
   always_comb begin
      item_in       = item_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      occ_in        = occ_ff;
      consumed_in   = consumed_ff;
      playing_in    = playing_ff;
      start_time_in = start_time_ff;
      due_in        = due_ff;
      mem_we        = 1'b0;
      status        = STATUS_OK;
      if (ctl.load) begin
         item_in = req_data;
      end
      if (ctl.exec) begin
         case (item_ff.cmd)
            CMD_STORE: begin
               if (occ_ff == OCC_W'(RING_DEPTH)) begin
                  status = STATUS_FULL;
               end else begin
                  mem_we    = 1'b1;
                  wr_ptr_in = ptr_next_f(wr_ptr_ff);
                  occ_in    = occ_ff + 1'b1;
                  // refill of an empty ring while playing is due at once
                  if ((occ_ff == '0) && playing_ff) begin
                     due_in = elapsed;
                  end
               end
            end
            CMD_START: begin
               if (occ_ff == '0) begin
                  status = STATUS_EMPTY;
               end else begin
                  playing_in    = 1'b1;
                  start_time_in = item_ff.now_us;
                  due_in        = '0;
               end
            end
            CMD_STOP: begin
               playing_in = 1'b0;
            end
            CMD_DISCARD: begin
               wr_ptr_in  = '0;
               rd_ptr_in  = '0;
               occ_in     = '0;
               playing_in = 1'b0;
               due_in     = '0;
            end
            default: begin
            end
         endcase
      end
      if (ctl.pop) begin
         rd_ptr_in   = ptr_next_f(rd_ptr_ff);
         occ_in      = occ_ff - 1'b1;
         consumed_in = consumed_ff + 1'b1;
         if (occ_in != '0) begin
            due_in = due_ff + ival_rd_ff;
         end
      end
   end

   // finished flag before and after this step
   assign fin_now  = playing_ff && (occ_ff == '0) && (consumed_ff >= total_ff);
   assign fin_next = playing_in && (occ_in == '0) && (consumed_in >= total_ff);

   // result and pending result
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      if (ctl.exec) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{status, 1'b0, 64'd0, vacancy_f(occ_in), fin_next, 1'b1};
      end
      if (ctl.pop) begin
         pend_in = '{STATUS_OK, 1'b1, set_rd_ff, vacancy_f(occ_in), fin_next, 1'b0};
         if (ctl.emit_prev) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
         end
      end
      if (ctl.flush) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pend_ff;
         rsp_in.last  = 1'b1;
      end
      if (ctl.idle_ack) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{STATUS_OK, 1'b0, 64'd0, vacancy_f(occ_ff), fin_now, 1'b1};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         occ_ff        <= '0;
         consumed_ff   <= '0;
         playing_ff    <= 1'b0;
         start_time_ff <= '0;
         due_ff        <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         occ_ff        <= occ_in;
         consumed_ff   <= consumed_in;
         playing_ff    <= playing_in;
         start_time_ff <= start_time_in;
         due_ff        <= due_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            total_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // ring write and registered head reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[wr_ptr_ff]  <= item_ff.joint_set & JOINT_MASK;
         ival_mem[wr_ptr_ff] <= item_ff.interval_us;
      end
      set_rd_ff  <= set_mem[rd_ptr_ff];
      ival_rd_ff <= ival_mem[ptr_next_f(rd_ptr_ff)];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tspr_checker.sv -----
// ----------------------------------------------------------------------------
// tspr_checker
// Port-level checks of the playback ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tspr_checker
   import tspr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire rsp_type     rsp_data
);

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting an item");

   // more results pending means the block is still busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> busy)
      else $error("non-final result while idle");

   // a released set always reports ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.applied) |-> (rsp_data.status == STATUS_OK))
      else $error("released set with error status");

   // no result without a preceding busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in progress");

endmodule

bind timed_sample_playback_ring_unit tspr_checker u_tspr_checker (.*);

`default_nettype wire

// ----- tb/tb_timed_sample_playback_ring_unit.sv -----
// ----------------------------------------------------------------------------
// tb_timed_sample_playback_ring_unit
// Self-checking bench for the paced joint-set playback ring. A local model of
// the ring, its timeline and the finished flag predicts every result. Short
// directed tests come first: idle commands, a full ring drained by one tick,
// re-anchoring and restart. Random playback sessions with random pacing and
// sample totals follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timed_sample_playback_ring_unit
   import tspr_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 450;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_DRAIN      = 40;
   localparam int REPORT_LINES   = 50;

   // command codes the block treats as no-ops
   localparam cmd_type CMD_SPARE_5 = 3'd5;
   localparam cmd_type CMD_SPARE_7 = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   req_type     req_data  = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data  = '0;

   // model of the ring and the playback timeline
   logic [63:0] ring_sets      [RING_DEPTH];
   logic [31:0] ring_intervals [RING_DEPTH];
   int          tail_idx       = 0;
   int          head_idx       = 0;
   int          fill_count     = 0;
   logic [31:0] released_total = '0;
   logic [31:0] anchor_time    = '0;
   logic [31:0] due_time       = '0;
   logic [31:0] sample_total   = '0;
   bit          is_playing     = 1'b0;

   rsp_type     pending_results[$];
   int          mismatches     = 0;
   int          accepted_items = 0;
   int          quiet_cycles   = 0;
   logic [31:0] now_us_ctr     = '0;
   bit          gapless        = 1'b0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   timed_sample_playback_ring_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   task automatic report_mismatch(string msg);
      if (mismatches < REPORT_LINES) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatches++;
   endtask

   // one result as seen after the state update that caused it
   function automatic rsp_type playback_result(status_type st, logic app, logic [63:0] set);
      rsp_type r;
      r.status     = st;
      r.applied    = app;
      r.drive_set  = set;
      r.vacancy    = 5'(RING_DEPTH - fill_count);
      r.finished   = is_playing && (fill_count == 0) && (released_total >= sample_total);
      r.last       = 1'b0;
      return r;
   endfunction

   // expected results of one accepted item
   task automatic predict_playback(req_type it);
      rsp_type     batch[$];
      rsp_type     final_rsp;
      logic [31:0] elapsed;
      logic [63:0] released_set;
      case (it.cmd)
         CMD_STORE: begin
            if (fill_count >= RING_DEPTH) begin
               batch.push_back(playback_result(STATUS_FULL, 1'b0, '0));
            end else begin
               // an empty ring while playing restarts the schedule at now
               if (fill_count == 0 && is_playing) begin
                  due_time = it.now_us - anchor_time;
               end
               ring_sets[tail_idx]      = it.joint_set & JOINT_MASK;
               ring_intervals[tail_idx] = it.interval_us;
               tail_idx = (tail_idx + 1) % RING_DEPTH;
               fill_count++;
               batch.push_back(playback_result(STATUS_OK, 1'b0, '0));
            end
         end
         CMD_START: begin
            if (fill_count == 0) begin
               batch.push_back(playback_result(STATUS_EMPTY, 1'b0, '0));
            end else begin
               is_playing  = 1'b1;
               anchor_time = it.now_us;
               due_time    = '0;
               batch.push_back(playback_result(STATUS_OK, 1'b0, '0));
            end
         end
         CMD_TICK: begin
            // release every due set, at most one burst per tick
            if (is_playing) begin
               while (fill_count > 0 && batch.size() < MAX_RESULTS) begin
                  elapsed = it.now_us - anchor_time;
                  if (elapsed < due_time) break;
                  released_set = ring_sets[head_idx];
                  head_idx = (head_idx + 1) % RING_DEPTH;
                  fill_count--;
                  released_total++;
                  if (fill_count > 0) begin
                     due_time += ring_intervals[head_idx];
                  end
                  batch.push_back(playback_result(STATUS_OK, 1'b1, released_set));
               end
            end
            if (batch.size() == 0) begin
               batch.push_back(playback_result(STATUS_OK, 1'b0, '0));
            end
         end
         CMD_STOP: begin
            is_playing = 1'b0;
            batch.push_back(playback_result(STATUS_OK, 1'b0, '0));
         end
         CMD_DISCARD: begin
            tail_idx   = 0;
            head_idx   = 0;
            fill_count = 0;
            is_playing = 1'b0;
            due_time   = '0;
            batch.push_back(playback_result(STATUS_OK, 1'b0, '0));
         end
         default: begin
            batch.push_back(playback_result(STATUS_OK, 1'b0, '0));
         end
      endcase
      final_rsp = batch.pop_back();
      final_rsp.last = 1'b1;
      batch.push_back(final_rsp);
      foreach (batch[i]) pending_results.push_back(batch[i]);
   endtask

   function automatic int pick_gap();
      int roll;
      if (gapless) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand_set();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rand_interval();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(0, 50);
      if (roll < 85) return $urandom_range(0, 500);
      if (roll < 90) return '0;
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_step();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 60);
      if (roll < 95) return $urandom_range(0, 400);
      return $urandom;
   endfunction

   // send one item; start stays high when the next item follows at once
   task automatic send_item(req_type it);
      int gap;
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      predict_playback(it);
      if (it.cmd <= CMD_DISCARD) accepted_items++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(cmd_type c, logic [31:0] now, logic [63:0] js, logic [31:0] iv);
      req_type it;
      it.cmd         = c;
      it.now_us      = now;
      it.joint_set   = js;
      it.interval_us = iv;
      send_item(it);
   endtask

   // wait until every expected result is in and the block has settled
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sample_total(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      sample_total = value;
   endtask

   // commands on an empty, stopped ring
   task automatic test_idle_commands();
      wait_idle();
      write_sample_total(32'hFFFF_FFFF);
      issue(CMD_TICK, $urandom, rand_set(), $urandom);
      issue(CMD_START, $urandom, rand_set(), $urandom);
      issue(CMD_STOP, $urandom, rand_set(), $urandom);
      issue(CMD_DISCARD, $urandom, rand_set(), $urandom);
      issue(CMD_SPARE_7, $urandom, rand_set(), $urandom);
   endtask

   // fill the ring, overflow it, then drain it all in one tick across a time wrap
   task automatic test_ring_limits();
      logic [63:0] js;
      logic [31:0] iv;
      wait_idle();
      write_sample_total('0);
      for (int i = 0; i < RING_DEPTH; i++) begin
         js = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : (i == 1) ? 64'h0 : rand_set();
         iv = (i == 0) ? 32'hFFFF_FFFF : 32'h0;
         issue(CMD_STORE, 32'(i), js, iv);
      end
      issue(CMD_STORE, 32'h0000_0100, rand_set(), 32'h0);
      issue(CMD_START, 32'hFFFF_FFF0, rand_set(), $urandom);
      issue(CMD_TICK, 32'h0000_0005, rand_set(), $urandom);
   endtask

   // store into an empty ring while playing, then restart while playing
   task automatic test_reanchor_and_restart();
      wait_idle();
      write_sample_total(released_total + 32'd1);
      issue(CMD_STORE, 32'h0000_1000, rand_set(), 32'hFFFF_FFFF);
      issue(CMD_TICK, 32'h0000_1000, rand_set(), $urandom);
      issue(CMD_STORE, 32'h0000_2000, rand_set(), 32'h0);
      issue(CMD_START, 32'h0000_2100, rand_set(), $urandom);
      issue(CMD_TICK, 32'h0000_2100, rand_set(), $urandom);
   endtask

   // random sessions: fill, start, paced ticks with disturbances and noise
   task automatic test_random_playback();
      int first;
      int n_store;
      int n_steps;
      int roll;
      first = accepted_items;
      while (accepted_items - first < RANDOM_ITEMS) begin
         wait_idle();
         roll = $urandom_range(0, 3);
         case (roll)
            0:       write_sample_total('0);
            1:       write_sample_total(32'hFFFF_FFFF);
            2:       write_sample_total(released_total + 32'($urandom_range(0, 20)));
            default: write_sample_total($urandom);
         endcase
         gapless    = ($urandom_range(0, 4) == 0);
         now_us_ctr = ($urandom_range(0, 5) == 0) ?
                      32'hFFFF_FFFF - 32'($urandom_range(0, 2000)) : $urandom;
         if ($urandom_range(0, 3) == 0) begin
            issue(CMD_DISCARD, now_us_ctr, rand_set(), $urandom);
         end

         // load the ring, sometimes past full
         n_store = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
         for (int i = 0; i < n_store; i++) begin
            now_us_ctr += 32'($urandom_range(0, 20));
            issue(CMD_STORE, now_us_ctr, rand_set(), rand_interval());
         end
         if ($urandom_range(0, 9) != 0) begin
            issue(CMD_START, now_us_ctr, rand_set(), $urandom);
         end

         // playback with occasional disturbance
         n_steps = $urandom_range(3, 20);
         for (int i = 0; i < n_steps; i++) begin
            now_us_ctr += rand_step();
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               issue(CMD_TICK, now_us_ctr, rand_set(), $urandom);
            end else if (roll < 80) begin
               issue(CMD_STORE, now_us_ctr, rand_set(), rand_interval());
            end else if (roll < 84) begin
               issue(CMD_START, now_us_ctr, rand_set(), $urandom);
            end else if (roll < 88) begin
               issue(CMD_STOP, now_us_ctr, rand_set(), $urandom);
            end else if (roll < 91) begin
               issue(CMD_DISCARD, now_us_ctr, rand_set(), $urandom);
            end else if (roll < 95) begin
               issue(cmd_type'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)), $urandom,
                     rand_set(), $urandom);
            end else begin
               issue(cmd_type'($urandom_range(0, 7)), $urandom, rand_set(), $urandom);
            end
         end
      end
      gapless = 1'b0;
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %h with none expected", rsp_data));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.applied !== want.applied)
               report_mismatch($sformatf("applied got %0d want %0d",
                                         rsp_data.applied, want.applied));
            if (rsp_data.drive_set !== want.drive_set)
               report_mismatch($sformatf("drive_set got %h want %h",
                                         rsp_data.drive_set, want.drive_set));
            if (rsp_data.vacancy !== want.vacancy)
               report_mismatch($sformatf("vacancy got %0d want %0d",
                                         rsp_data.vacancy, want.vacancy));
            if (rsp_data.finished !== want.finished)
               report_mismatch($sformatf("finished got %0d want %0d",
                                         rsp_data.finished, want.finished));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last got %0d want %0d",
                                         rsp_data.last, want.last));
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timed_sample_playback_ring_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_ring_limits();
      test_reanchor_and_restart();
      test_random_playback();
      wait_idle();
      repeat (END_DRAIN) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("timed_sample_playback_ring_unit verification clean");
      end else begin
         $display("timed_sample_playback_ring_unit verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/tspr_pkg.sv
hw/rtl/tspr_ctrl.sv
hw/rtl/tspr_datapath.sv
hw/rtl/timed_sample_playback_ring_unit.sv
hw/rtl/tspr_checker.sv
tb/tb_timed_sample_playback_ring_unit.sv
